@@ hdl/hsbrgb_pkg.sv @@
// ----------------------------------------------------------------------------
// hsbrgb_pkg: shared types and constants for the hsb to rgb converter
// fixed-point formats, stage records and hue sector codes
// ----------------------------------------------------------------------------
package hsbrgb_pkg;

	// number formats
	localparam int HUE_BITS        = 16;
	localparam int LEVEL_FRAC_BITS = 15;
	localparam int CHAN_W          = 8;

	// level with one integer bit, so 1.0 fits
	localparam int LVL_W       = LEVEL_FRAC_BITS + 1;
	// brightness times 255
	localparam int VSC_W       = LEVEL_FRAC_BITS + CHAN_W;
	// level multiplier, up to one times a full hue turn
	localparam int MUL_W       = LEVEL_FRAC_BITS + HUE_BITS + 1;
	localparam int TOTAL_SHIFT = 2 * LEVEL_FRAC_BITS + HUE_BITS;
	localparam int PQ_W        = TOTAL_SHIFT + CHAN_W;
	localparam int P_SHIFT     = 2 * LEVEL_FRAC_BITS;
	localparam int PP_W        = P_SHIFT + CHAN_W;

	localparam logic [LVL_W-1:0]    LVL_ONE  = LVL_W'(1) << LEVEL_FRAC_BITS;
	localparam logic [HUE_BITS:0]   HUE_ONE  = (HUE_BITS+1)'(1) << HUE_BITS;
	localparam logic [MUL_W-1:0]    FULL_MUL = MUL_W'(1) << (MUL_W - 1);
	localparam logic [PQ_W-1:0]     RND_Q    = PQ_W'(1) << (TOTAL_SHIFT - 1);
	localparam logic [PP_W-1:0]     RND_P    = PP_W'(1) << (P_SHIFT - 1);
	localparam logic [VSC_W-1:0]    RND_V    = VSC_W'(1) << (LEVEL_FRAC_BITS - 1);

	// six hue sectors, named by the color at their start
	typedef enum logic [2:0] {
		SEC_RED     = 3'd0,
		SEC_YELLOW  = 3'd1,
		SEC_GREEN   = 3'd2,
		SEC_CYAN    = 3'd3,
		SEC_BLUE    = 3'd4,
		SEC_MAGENTA = 3'd5
	} sector_t;

	// stage 1: clamped levels and hue position
	typedef struct packed {
		sector_t             sector;
		logic [LVL_W-1:0]    sat;
		logic [HUE_BITS-1:0] frac;
		logic [HUE_BITS:0]   frac_c;
		logic [VSC_W-1:0]    vscaled;
	} s1_t;

	// stage 2: level multipliers
	typedef struct packed {
		sector_t          sector;
		logic [VSC_W-1:0] vscaled;
		logic [LVL_W-1:0] sat_c;
		logic [MUL_W-1:0] mul_q;
		logic [MUL_W-1:0] mul_t;
	} s2_t;

	// stage 3: scaled products before rounding
	typedef struct packed {
		sector_t          sector;
		logic [VSC_W-1:0] vscaled;
		logic [PP_W-1:0]  prod_p;
		logic [PQ_W-1:0]  prod_q;
		logic [PQ_W-1:0]  prod_t;
	} s3_t;

	// result pixel, red in the low bits
	typedef struct packed {
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
	} rgb_t;

endpackage

@@ hdl/hsbrgb_sector.sv @@
// ----------------------------------------------------------------------------
// hsbrgb_sector: first pipeline stage
// clamps levels, splits hue into sector and fraction, scales brightness by 255
// ----------------------------------------------------------------------------
module hsbrgb_sector (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_vld,
	output logic                               in_rdy,
	input  logic [hsbrgb_pkg::HUE_BITS-1:0]    hue_frac,
	input  logic [hsbrgb_pkg::LVL_W-1:0]       sat_level,
	input  logic [hsbrgb_pkg::LVL_W-1:0]       bright_level,
	output logic                               vld_s1,
	input  logic                               out_rdy,
	output hsbrgb_pkg::s1_t                    data_s1
);

	logic [hsbrgb_pkg::HUE_BITS+2:0]  h6;
	logic [hsbrgb_pkg::LVL_W-1:0]     sat_c;
	logic [hsbrgb_pkg::LVL_W-1:0]     bri_c;
	logic [hsbrgb_pkg::VSC_W:0]       vsc_full;
	hsbrgb_pkg::s1_t                  nxt;

	// stage advances when empty or when downstream takes it
	assign in_rdy = !vld_s1 || out_rdy;

	// clamp levels above one
	assign sat_c = (sat_level > hsbrgb_pkg::LVL_ONE) ? hsbrgb_pkg::LVL_ONE : sat_level;
	assign bri_c = (bright_level > hsbrgb_pkg::LVL_ONE) ? hsbrgb_pkg::LVL_ONE : bright_level;

	// hue times six by shift and add
	assign h6 = ({3'b000, hue_frac} << 2) + ({3'b000, hue_frac} << 1);

	// brightness times 255
	assign vsc_full = ({bri_c, {hsbrgb_pkg::CHAN_W{1'b0}}})
		- {{hsbrgb_pkg::CHAN_W{1'b0}}, bri_c};

	always_comb begin
		nxt.sector  = hsbrgb_pkg::sector_t'(h6[hsbrgb_pkg::HUE_BITS+2:hsbrgb_pkg::HUE_BITS]);
		nxt.sat     = sat_c;
		nxt.frac    = h6[hsbrgb_pkg::HUE_BITS-1:0];
		nxt.frac_c  = hsbrgb_pkg::HUE_ONE - {1'b0, h6[hsbrgb_pkg::HUE_BITS-1:0]};
		nxt.vscaled = vsc_full[hsbrgb_pkg::VSC_W-1:0];
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_rdy) begin
			vld_s1 <= in_vld;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_vld && in_rdy) begin
			data_s1 <= nxt;
		end
	end

endmodule

@@ hdl/hsbrgb_level.sv @@
// ----------------------------------------------------------------------------
// hsbrgb_level: second pipeline stage
// forms the level multipliers for p, q and t from saturation and hue fraction
// ----------------------------------------------------------------------------
module hsbrgb_level (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vld_s1,
	output logic             in_rdy,
	input  hsbrgb_pkg::s1_t  data_s1,
	output logic             vld_s2,
	input  logic             out_rdy,
	output hsbrgb_pkg::s2_t  data_s2
);

	logic [hsbrgb_pkg::MUL_W-1:0]  sf;
	logic [hsbrgb_pkg::MUL_W:0]    sfc;
	hsbrgb_pkg::s2_t               nxt;

	assign in_rdy = !vld_s2 || out_rdy;

	// saturation times fraction and its complement
	assign sf  = data_s1.sat * data_s1.frac;
	assign sfc = data_s1.sat * data_s1.frac_c;

	always_comb begin
		nxt.sector  = data_s1.sector;
		nxt.vscaled = data_s1.vscaled;
		nxt.sat_c   = hsbrgb_pkg::LVL_ONE - data_s1.sat;
		nxt.mul_q   = hsbrgb_pkg::FULL_MUL - sf;
		nxt.mul_t   = hsbrgb_pkg::FULL_MUL - sfc[hsbrgb_pkg::MUL_W-1:0];
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (in_rdy) begin
			vld_s2 <= vld_s1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (vld_s1 && in_rdy) begin
			data_s2 <= nxt;
		end
	end

endmodule

@@ hdl/hsbrgb_scale.sv @@
// ----------------------------------------------------------------------------
// hsbrgb_scale: third pipeline stage
// multiplies scaled brightness by each level multiplier
// ----------------------------------------------------------------------------
module hsbrgb_scale (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vld_s2,
	output logic             in_rdy,
	input  hsbrgb_pkg::s2_t  data_s2,
	output logic             vld_s3,
	input  logic             out_rdy,
	output hsbrgb_pkg::s3_t  data_s3
);

	logic [hsbrgb_pkg::VSC_W+hsbrgb_pkg::MUL_W-1:0]  pq;
	logic [hsbrgb_pkg::VSC_W+hsbrgb_pkg::MUL_W-1:0]  pt;
	logic [hsbrgb_pkg::VSC_W+hsbrgb_pkg::LVL_W-1:0]  pp;
	hsbrgb_pkg::s3_t                                 nxt;

	assign in_rdy = !vld_s3 || out_rdy;

	// one multiplier per level
	assign pq = data_s2.vscaled * data_s2.mul_q;
	assign pt = data_s2.vscaled * data_s2.mul_t;
	assign pp = data_s2.vscaled * data_s2.sat_c;

	always_comb begin
		nxt.sector  = data_s2.sector;
		nxt.vscaled = data_s2.vscaled;
		nxt.prod_p  = pp[hsbrgb_pkg::PP_W-1:0];
		nxt.prod_q  = pq[hsbrgb_pkg::PQ_W-1:0];
		nxt.prod_t  = pt[hsbrgb_pkg::PQ_W-1:0];
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (in_rdy) begin
			vld_s3 <= vld_s2;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (vld_s2 && in_rdy) begin
			data_s3 <= nxt;
		end
	end

endmodule

@@ hdl/hsbrgb_round.sv @@
// ----------------------------------------------------------------------------
// hsbrgb_round: fourth pipeline stage and output register
// rounds each level half up to 8 bits and routes them by hue sector
// ----------------------------------------------------------------------------
module hsbrgb_round (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld_s3,
	output logic              in_rdy,
	input  hsbrgb_pkg::s3_t   data_s3,
	output logic              vld_s4,
	input  logic              out_rdy,
	output hsbrgb_pkg::rgb_t  data_s4
);

	logic [hsbrgb_pkg::VSC_W-1:0]   sum_v;
	logic [hsbrgb_pkg::PP_W-1:0]    sum_p;
	logic [hsbrgb_pkg::PQ_W-1:0]    sum_q;
	logic [hsbrgb_pkg::PQ_W-1:0]    sum_t;
	logic [hsbrgb_pkg::CHAN_W-1:0]  cv;
	logic [hsbrgb_pkg::CHAN_W-1:0]  cp;
	logic [hsbrgb_pkg::CHAN_W-1:0]  cq;
	logic [hsbrgb_pkg::CHAN_W-1:0]  ct;
	hsbrgb_pkg::rgb_t               nxt;

	assign in_rdy = !vld_s4 || out_rdy;

	// round half up, keep the top byte
	assign sum_v = data_s3.vscaled + hsbrgb_pkg::RND_V;
	assign sum_p = data_s3.prod_p + hsbrgb_pkg::RND_P;
	assign sum_q = data_s3.prod_q + hsbrgb_pkg::RND_Q;
	assign sum_t = data_s3.prod_t + hsbrgb_pkg::RND_Q;

	assign cv = sum_v[hsbrgb_pkg::VSC_W-1:hsbrgb_pkg::LEVEL_FRAC_BITS];
	assign cp = sum_p[hsbrgb_pkg::PP_W-1:hsbrgb_pkg::P_SHIFT];
	assign cq = sum_q[hsbrgb_pkg::PQ_W-1:hsbrgb_pkg::TOTAL_SHIFT];
	assign ct = sum_t[hsbrgb_pkg::PQ_W-1:hsbrgb_pkg::TOTAL_SHIFT];

	// sector routing of v, p, q, t to red, green, blue
	always_comb begin
		unique case (data_s3.sector)
			hsbrgb_pkg::SEC_RED: begin
				nxt.red = cv; nxt.green = ct; nxt.blue = cp;
			end
			hsbrgb_pkg::SEC_YELLOW: begin
				nxt.red = cq; nxt.green = cv; nxt.blue = cp;
			end
			hsbrgb_pkg::SEC_GREEN: begin
				nxt.red = cp; nxt.green = cv; nxt.blue = ct;
			end
			hsbrgb_pkg::SEC_CYAN: begin
				nxt.red = cp; nxt.green = cq; nxt.blue = cv;
			end
			hsbrgb_pkg::SEC_BLUE: begin
				nxt.red = ct; nxt.green = cp; nxt.blue = cv;
			end
			default: begin
				nxt.red = cv; nxt.green = cp; nxt.blue = cq;
			end
		endcase
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (in_rdy) begin
			vld_s4 <= vld_s3;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (vld_s3 && in_rdy) begin
			data_s4 <= nxt;
		end
	end

endmodule

@@ hdl/hsb_to_rgb_converter_top.sv @@
// an accepted input transaction moves through the stage 1 to stage 4 registers to its output transaction
// throughput: one pixel per cycle while the output is not stalled; each of the four stages holds one pixel
// a stalled output backs up only full stages, bubbles are squeezed out
// the multipliers of stages 2 and 3 (up to 23 x 32 bits) set the depth of those stages
// reset: arst_n clears all valid bits at once, payload registers are not reset
// ----------------------------------------------------------------------------
// hsb_to_rgb_converter_top: hue, saturation, brightness to 8-bit rgb
// six-sector conversion in a four-stage pipeline with stream handshakes
// ----------------------------------------------------------------------------
module hsb_to_rgb_converter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // hue_frac[15:0], sat_level[31:16], bright_level[47:32]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata    // red_out[7:0], green_out[15:8], blue_out[23:16]
);

	logic              vld_s1;
	logic              vld_s2;
	logic              vld_s3;
	logic              vld_s4;
	logic              rdy_s2;
	logic              rdy_s3;
	logic              rdy_s4;
	hsbrgb_pkg::s1_t   data_s1;
	hsbrgb_pkg::s2_t   data_s2;
	hsbrgb_pkg::s3_t   data_s3;
	hsbrgb_pkg::rgb_t  data_s4;

	// stage 1: clamp and hue sector
	hsbrgb_sector u_sector (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_vld       (s_axis_tvalid),
		.in_rdy       (s_axis_tready),
		.hue_frac     (s_axis_tdata[15:0]),
		.sat_level    (s_axis_tdata[31:16]),
		.bright_level (s_axis_tdata[47:32]),
		.vld_s1       (vld_s1),
		.out_rdy      (rdy_s2),
		.data_s1      (data_s1)
	);

	// stage 2: level multipliers
	hsbrgb_level u_level (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_s1  (vld_s1),
		.in_rdy  (rdy_s2),
		.data_s1 (data_s1),
		.vld_s2  (vld_s2),
		.out_rdy (rdy_s3),
		.data_s2 (data_s2)
	);

	// stage 3: brightness products
	hsbrgb_scale u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_s2  (vld_s2),
		.in_rdy  (rdy_s3),
		.data_s2 (data_s2),
		.vld_s3  (vld_s3),
		.out_rdy (rdy_s4),
		.data_s3 (data_s3)
	);

	// stage 4: rounding, routing, output register
	hsbrgb_round u_round (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_s3  (vld_s3),
		.in_rdy  (rdy_s4),
		.data_s3 (data_s3),
		.vld_s4  (vld_s4),
		.out_rdy (m_axis_tready),
		.data_s4 (data_s4)
	);

	assign m_axis_tvalid = vld_s4;
	assign m_axis_tdata  = data_s4;

	// input is refused only when every stage is occupied
	a_full_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4))
		else $error("input stalled with an empty stage");

	// an accepted transaction always lands in stage 1
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> vld_s1)
		else $error("accepted transaction lost at stage 1");

	// a held output keeps every stage behind it full
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && vld_s2 && vld_s3 && vld_s4 && !m_axis_tready)
		|=> (vld_s1 && vld_s2 && vld_s3 && vld_s4))
		else $error("stage emptied during output stall");

endmodule
